// ----- design/fete_pkg.sv -----
// Shared types, constants and helpers for the escape-time fractal engine.
// Used by every module of the block but the checker; depends on nothing else.
package fete_pkg;

  localparam int FRAC_BITS       = 28;
  localparam int WORD_BITS       = FRAC_BITS + 4;
  localparam int STEP_BITS       = 31;
  localparam int ITER_BITS       = 16;
  localparam int CFG_INDEX_BITS  = 8;
  localparam int CFG_DATA_BITS   = 32;
  localparam int COORD_BITS_DEF  = 12;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Wide signed intermediate: holds pixel mapping sums and iteration sums
  localparam int SAT_IN_BITS = 50;
  // Square magnitude after dropping fraction bits
  localparam int SQ_BITS = 2 * WORD_BITS - FRAC_BITS;
  // Doubled cross product after dropping fraction bits
  localparam int TW_BITS = 2 * WORD_BITS - FRAC_BITS + 1;

  localparam logic [SQ_BITS:0] FOUR_Q =
    {{(SQ_BITS - FRAC_BITS - 2){1'b0}}, 3'b100, {FRAC_BITS{1'b0}}};

  typedef logic signed [WORD_BITS-1:0]   word_t;
  typedef logic signed [SAT_IN_BITS-1:0] wide_t;

  typedef enum logic [1:0] {
    MODE_MANDEL  = 2'd0,
    MODE_JULIA   = 2'd1,
    MODE_TRICORN = 2'd2,
    MODE_SHIP    = 2'd3
  } mode_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MODE      = 8'd0,
    REG_MAX_ITER  = 8'd1,
    REG_STEP_RE   = 8'd2,
    REG_STEP_IM   = 8'd3,
    REG_ORIGIN_RE = 8'd4,
    REG_ORIGIN_IM = 8'd5,
    REG_JULIA_RE  = 8'd6,
    REG_JULIA_IM  = 8'd7
  } reg_index_t;

  typedef struct packed {
    mode_t                 mode;
    logic [ITER_BITS-1:0]  max_iter;
    logic [STEP_BITS-1:0]  step_re;
    logic [STEP_BITS-1:0]  step_im;
    word_t                 origin_re;
    word_t                 origin_im;
    word_t                 julia_re;
    word_t                 julia_im;
  } cfg_regs_t;

  localparam mode_t                RST_MODE      = MODE_MANDEL;
  localparam logic [ITER_BITS-1:0] RST_MAX_ITER  = 16'd50;
  localparam logic [STEP_BITS-1:0] RST_STEP_RE   = 31'd1342177;
  localparam logic [STEP_BITS-1:0] RST_STEP_IM   = 31'd1342177;
  localparam word_t                RST_ORIGIN_RE = -32'sd671088640;
  localparam word_t                RST_ORIGIN_IM = -32'sd335544320;
  localparam word_t                RST_JULIA_RE  = 32'sd0;
  localparam word_t                RST_JULIA_IM  = 32'sd0;

  function automatic wide_t sext_wide(input word_t v);
    return {{(SAT_IN_BITS - WORD_BITS){v[WORD_BITS-1]}}, v};
  endfunction

  // Clamp a wide signed value to the word range
  function automatic word_t sat_word(input wide_t v);
    logic [SAT_IN_BITS-WORD_BITS:0] top;
    top = v[SAT_IN_BITS-1:WORD_BITS-1];
    if ((&top) || !(|top)) begin
      return v[WORD_BITS-1:0];
    end else if (v[SAT_IN_BITS-1]) begin
      return {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_BITS-1){1'b1}}};
    end
  endfunction

endpackage

// ----- design/fete_front.sv -----
// Front end: takes a pixel, scales it by the step registers and adds the origin.
// Depends on fete_pkg; feeds fete_queue.
module fete_front #(
  parameter int COORD_BITS = fete_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fete_pkg::cfg_regs_t     cfg,
  input  logic                    start,
  output logic                    busy,
  input  logic [COORD_BITS-1:0]   in_pixel_x,
  input  logic [COORD_BITS-1:0]   in_pixel_y,
  output logic                    push,
  input  logic                    push_ready,
  output logic [COORD_BITS-1:0]   push_x,
  output logic [COORD_BITS-1:0]   push_y,
  output fete_pkg::word_t         push_re,
  output fete_pkg::word_t         push_im
);
  import fete_pkg::*;

  localparam int PROD_BITS = COORD_BITS + STEP_BITS;

  logic                  vld_r;
  logic [COORD_BITS-1:0] x_r;
  logic [COORD_BITS-1:0] y_r;
  logic [PROD_BITS-1:0]  prod_re_r;
  logic [PROD_BITS-1:0]  prod_im_r;
  logic                  accept;
  wide_t                 sum_re;
  wide_t                 sum_im;

  assign busy   = vld_r && !push_ready;
  assign accept = start && !busy;
  assign push   = vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (accept) begin
      vld_r <= 1'b1;
    end else if (push_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r       <= in_pixel_x;
      y_r       <= in_pixel_y;
      prod_re_r <= PROD_BITS'(in_pixel_x) * PROD_BITS'(cfg.step_re);
      prod_im_r <= PROD_BITS'(in_pixel_y) * PROD_BITS'(cfg.step_im);
    end
  end

  assign sum_re = sext_wide(cfg.origin_re) + SAT_IN_BITS'(prod_re_r);
  assign sum_im = sext_wide(cfg.origin_im) + SAT_IN_BITS'(prod_im_r);

  assign push_x  = x_r;
  assign push_y  = y_r;
  assign push_re = sat_word(sum_re);
  assign push_im = sat_word(sum_im);

endmodule

// ----- design/fete_queue.sv -----
// Short FIFO between the pixel mapper and the iteration engine.
// Depends on fete_pkg for the default depth.
module fete_queue #(
  parameter int DATA_BITS = 64,
  parameter int DEPTH     = fete_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output logic [DATA_BITS-1:0] pop_data
);
  import fete_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);

  logic [DATA_BITS-1:0] mem_r [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_r;
  logic [PTR_BITS-1:0]  rd_ptr_r;
  logic [PTR_BITS:0]    fill_r;
  logic                 do_push;
  logic                 do_pop;

  assign full     = (fill_r == (PTR_BITS + 1)'(DEPTH));
  assign empty    = (fill_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/fete_iter.sv -----
// Back end: iterates the selected map with one shared 32x32 multiplier and
// counts steps until escape or the limit. Depends on fete_pkg.
module fete_iter #(
  parameter int COORD_BITS = fete_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fete_pkg::cfg_regs_t            cfg,
  input  logic                           q_empty,
  output logic                           q_pop,
  input  logic [COORD_BITS-1:0]          q_x,
  input  logic [COORD_BITS-1:0]          q_y,
  input  fete_pkg::word_t                q_re,
  input  fete_pkg::word_t                q_im,
  output logic                           out_valid,
  output logic [COORD_BITS-1:0]          out_x,
  output logic [COORD_BITS-1:0]          out_y,
  output logic [fete_pkg::ITER_BITS-1:0] out_count
);
  import fete_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ_R,
    S_SQ_I,
    S_CROSS,
    S_UPD
  } state_t;

  state_t                 state_r;
  word_t                  zr_r;
  word_t                  zi_r;
  word_t                  cr_r;
  word_t                  ci_r;
  logic [ITER_BITS-1:0]   count_r;
  logic [COORD_BITS-1:0]  x_r;
  logic [COORD_BITS-1:0]  y_r;
  logic [2*WORD_BITS-1:0] prod_r;
  logic [SQ_BITS-1:0]     sr_r;
  logic [SQ_BITS-1:0]     si_r;
  logic                   out_valid_r;
  logic [COORD_BITS-1:0]  out_x_r;
  logic [COORD_BITS-1:0]  out_y_r;
  logic [ITER_BITS-1:0]   out_count_r;

  logic [WORD_BITS-1:0]   mr;
  logic [WORD_BITS-1:0]   mi;
  logic [WORD_BITS-1:0]   mul_a;
  logic [WORD_BITS-1:0]   mul_b;
  logic [2*WORD_BITS-1:0] mul_p;
  logic [SQ_BITS:0]       mag_sum;
  logic                   escape;
  logic                   neg_sel;
  logic [TW_BITS-1:0]     tw_floor;
  logic [TW_BITS:0]       tw_ceil;
  wide_t                  tw;
  wide_t                  zi_sum;
  wide_t                  zr_sum;

  assign mr = zr_r[WORD_BITS-1] ? (~zr_r + 1'b1) : zr_r;
  assign mi = zi_r[WORD_BITS-1] ? (~zi_r + 1'b1) : zi_r;

  always_comb begin
    unique case (state_r)
      S_SQ_R: begin
        mul_a = mr;
        mul_b = mr;
      end
      S_SQ_I: begin
        mul_a = mi;
        mul_b = mi;
      end
      default: begin
        mul_a = mr;
        mul_b = mi;
      end
    endcase
  end

  assign mul_p = (2*WORD_BITS)'(mul_a) * (2*WORD_BITS)'(mul_b);

  assign mag_sum = {1'b0, sr_r} + {1'b0, si_r};
  assign escape  = (mag_sum >= FOUR_Q);

  // Sign of the doubled cross term per map
  always_comb begin
    unique case (cfg.mode)
      MODE_TRICORN: neg_sel = !(zr_r[WORD_BITS-1] ^ zi_r[WORD_BITS-1]);
      MODE_SHIP:    neg_sel = 1'b0;
      default:      neg_sel = zr_r[WORD_BITS-1] ^ zi_r[WORD_BITS-1];
    endcase
  end

  // Negative products round toward minus infinity: negate the rounded-up magnitude
  assign tw_floor = prod_r[2*WORD_BITS-1:FRAC_BITS-1];
  assign tw_ceil  = {1'b0, tw_floor} + (TW_BITS + 1)'(|prod_r[FRAC_BITS-2:0]);
  assign tw       = neg_sel ? -$signed(SAT_IN_BITS'(tw_ceil))
                            : $signed(SAT_IN_BITS'(tw_floor));
  assign zi_sum   = (cfg.mode == MODE_MANDEL) ? tw - sext_wide(ci_r)
                                              : tw + sext_wide(ci_r);
  assign zr_sum   = $signed(SAT_IN_BITS'(sr_r)) - $signed(SAT_IN_BITS'(si_r))
                    + sext_wide(cr_r);

  assign q_pop = (state_r == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            x_r     <= q_x;
            y_r     <= q_y;
            count_r <= '0;
            if (cfg.mode == MODE_JULIA) begin
              zr_r <= q_re;
              zi_r <= q_im;
              cr_r <= cfg.julia_re;
              ci_r <= cfg.julia_im;
            end else begin
              zr_r <= '0;
              zi_r <= '0;
              cr_r <= q_re;
              ci_r <= q_im;
            end
            state_r <= S_SQ_R;
          end
        end
        S_SQ_R: begin
          if (count_r >= cfg.max_iter) begin
            out_valid_r <= 1'b1;
            out_x_r     <= x_r;
            out_y_r     <= y_r;
            out_count_r <= count_r;
            state_r     <= S_IDLE;
          end else begin
            prod_r  <= mul_p;
            state_r <= S_SQ_I;
          end
        end
        S_SQ_I: begin
          sr_r    <= prod_r[2*WORD_BITS-1:FRAC_BITS];
          prod_r  <= mul_p;
          state_r <= S_CROSS;
        end
        S_CROSS: begin
          si_r    <= prod_r[2*WORD_BITS-1:FRAC_BITS];
          prod_r  <= mul_p;
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (escape) begin
            out_valid_r <= 1'b1;
            out_x_r     <= x_r;
            out_y_r     <= y_r;
            out_count_r <= count_r;
            state_r     <= S_IDLE;
          end else begin
            zr_r    <= sat_word(zr_sum);
            zi_r    <= sat_word(zi_sum);
            count_r <= count_r + 1'b1;
            state_r <= S_SQ_R;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_count = out_count_r;

endmodule

// ----- design/fractal_escape_time_engine.sv -----
// Top level of the escape-time fractal engine: configuration registers,
// pixel mapper, queue and iteration engine. Depends on fete_pkg and submodules.
//
// One pixel in (start while busy is low), one result out as a single-cycle
// out_valid strobe that the receiver must take. The iteration engine takes
// each map step through S_SQ_R, S_SQ_I, S_CROSS and S_UPD: its one 32x32
// multiplier makes the real square, the imaginary square and the cross
// product in turn, then S_UPD updates. A pixel leaves on escape or when its
// step count reaches the limit. The pixel mapper registers each pixel before
// the queue push and keeps accepting pixels while the queue has room,
// so input stalls only when the mapper and queue are both full. Write the
// configuration only while no pixel is in flight.
module fractal_escape_time_engine #(
  parameter int COORD_BITS = fete_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS = fete_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [COORD_BITS-1:0]               in_pixel_x,
  input  logic [COORD_BITS-1:0]               in_pixel_y,
  output logic                                out_valid,
  output logic [COORD_BITS-1:0]               out_x,
  output logic [COORD_BITS-1:0]               out_y,
  output logic [COUNT_BITS-1:0]               out_iteration_count,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fete_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [fete_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import fete_pkg::*;

  localparam int Q_BITS = 2 * COORD_BITS + 2 * WORD_BITS;

  cfg_regs_t             cfg_r;
  logic                  f_push;
  logic                  q_full;
  logic [COORD_BITS-1:0] f_x;
  logic [COORD_BITS-1:0] f_y;
  word_t                 f_re;
  word_t                 f_im;
  logic                  q_pop;
  logic                  q_empty;
  logic [Q_BITS-1:0]     q_data;
  logic [COORD_BITS-1:0] q_x;
  logic [COORD_BITS-1:0] q_y;
  word_t                 q_re;
  word_t                 q_im;
  logic [ITER_BITS-1:0]  iter_count;

  assign cfg_ready = 1'b1;

  // Drop writes to indexes beyond the register list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= RST_MODE;
      cfg_r.max_iter  <= RST_MAX_ITER;
      cfg_r.step_re   <= RST_STEP_RE;
      cfg_r.step_im   <= RST_STEP_IM;
      cfg_r.origin_re <= RST_ORIGIN_RE;
      cfg_r.origin_im <= RST_ORIGIN_IM;
      cfg_r.julia_re  <= RST_JULIA_RE;
      cfg_r.julia_im  <= RST_JULIA_IM;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:      cfg_r.mode      <= mode_t'(cfg_data[1:0]);
        REG_MAX_ITER:  cfg_r.max_iter  <= cfg_data[ITER_BITS-1:0];
        REG_STEP_RE:   cfg_r.step_re   <= cfg_data[STEP_BITS-1:0];
        REG_STEP_IM:   cfg_r.step_im   <= cfg_data[STEP_BITS-1:0];
        REG_ORIGIN_RE: cfg_r.origin_re <= cfg_data[WORD_BITS-1:0];
        REG_ORIGIN_IM: cfg_r.origin_im <= cfg_data[WORD_BITS-1:0];
        REG_JULIA_RE:  cfg_r.julia_re  <= cfg_data[WORD_BITS-1:0];
        REG_JULIA_IM:  cfg_r.julia_im  <= cfg_data[WORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  fete_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .start      (start),
    .busy       (busy),
    .in_pixel_x (in_pixel_x),
    .in_pixel_y (in_pixel_y),
    .push       (f_push),
    .push_ready (!q_full),
    .push_x     (f_x),
    .push_y     (f_y),
    .push_re    (f_re),
    .push_im    (f_im)
  );

  fete_queue #(
    .DATA_BITS (Q_BITS),
    .DEPTH     (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data ({f_x, f_y, f_re, f_im}),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_data)
  );

  assign {q_x, q_y, q_re, q_im} = q_data;

  fete_iter #(
    .COORD_BITS (COORD_BITS)
  ) u_iter (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_x       (q_x),
    .q_y       (q_y),
    .q_re      (q_re),
    .q_im      (q_im),
    .out_valid (out_valid),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_count (iter_count)
  );

  assign out_iteration_count = COUNT_BITS'(iter_count);

endmodule

// ----- design/fete_checker.sv -----
// Port-level checks for the escape-time fractal engine, bound to the top level.
// Depends only on the top level's ports.
module fete_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  logic [7:0] pending_r;

  // Track pixels taken but not yet reported
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 8'(start && !busy) - 8'(out_valid);
    end
  end

  a_out_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobes in back-to-back cycles");

  a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (!out_valid && !busy))
    else $error("activity right after reset");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && $past(rst_n)) |-> ($past(busy) || $past(start)))
    else $error("busy without a prior transaction");

  a_out_owed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pending_r != 8'd0))
    else $error("result without a pending transaction");

endmodule

bind fractal_escape_time_engine fete_checker u_fete_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
